// File: rtl/positional_list_engine_defines.svh
// assertion macros for the positional list engine
// depends on clk_i and rst_ni being visible in the module that uses them
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PLE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define PLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ple_pkg.sv
// shared types and constants of the positional list engine
// no dependencies
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int ST_W     = 3;
  localparam int CMP_W    = POS_W + CNT_W;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // one result beat handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [POS_W-1:0] found_position;
    logic             last;
  } push_t;

  // memory command from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_cmd_t;

endpackage

// File: rtl/ple_req_if.sv
// request channel of the positional list engine
// depends on ple_pkg
interface ple_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic signed [ple_pkg::DATA_W-1:0] value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source (output valid, output req_type, output value, output position, input ready);
  modport sink (input valid, input req_type, input value, input position, output ready);
endinterface

// File: rtl/ple_rsp_if.sv
// result channel of the positional list engine
// depends on ple_pkg
interface ple_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ple_pkg::ST_W-1:0]  status;
  logic [ple_pkg::POS_W-1:0] found_position;
  logic                      last;

  modport source (output valid, output status, output found_position, output last, input ready);
  modport sink (input valid, input status, input found_position, input last, output ready);
endinterface

// File: rtl/ple_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ple_ram #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ple_ctrl.sv
// request sequencer: dispatch, search scan and delete shift over the entry ram
// depends on ple_pkg, ple_req_if and positional_list_engine_defines.svh
`include "positional_list_engine_defines.svh"

module ple_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ple_req_if.sink                        req_i,
  input  logic                           push_ok_i,
  output ple_pkg::push_t                 push_o,
  output ple_pkg::mem_cmd_t              mem_o,
  input  logic [ple_pkg::DATA_W-1:0]     rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DISP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [ple_pkg::CNT_W-1:0]      count_q, count_d;
  logic [ple_pkg::CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic [ple_pkg::CNT_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                           cmp_valid_q, cmp_valid_d;
  logic                           pend_q, pend_d;
  logic [ple_pkg::POS_W-1:0]      pend_pos_q, pend_pos_d;

  ple_pkg::req_e                  req_q;
  logic [ple_pkg::DATA_W-1:0]     value_q;
  logic [ple_pkg::POS_W-1:0]      pos_q;

  logic                           full;
  logic                           empty;
  logic                           bad_pos;
  logic                           more;
  logic                           match;
  logic                           stall;
  logic [ple_pkg::POS_W-1:0]      pos_m1;

  assign req_i.ready = (state_q == S_IDLE);

  assign full    = (count_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty   = (count_q == '0);
  assign bad_pos = (pos_q == '0) ||
                   (ple_pkg::CMP_W'(pos_q) > ple_pkg::CMP_W'(count_q));
  assign more    = (rd_idx_q < count_q);
  assign match   = (rdata_i == value_q);
  assign pos_m1  = pos_q - 1'b1;
  // a second match cannot retire the held one while the output is busy
  assign stall   = cmp_valid_q && match && pend_q && !push_ok_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = cmp_valid_q;
    pend_d      = pend_q;
    pend_pos_d  = pend_pos_q;

    push_o.valid          = 1'b0;
    push_o.status         = ple_pkg::ST_OK;
    push_o.found_position = '0;
    push_o.last           = 1'b1;

    mem_o.we    = 1'b0;
    mem_o.waddr = ple_pkg::IDX_W'(count_q);
    mem_o.wdata = value_q;
    mem_o.re    = 1'b0;
    mem_o.raddr = ple_pkg::IDX_W'(rd_idx_q);

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        case (req_q)
          ple_pkg::REQ_APPEND: begin
            if (push_ok_i) begin
              push_o.valid = 1'b1;
              state_d      = S_IDLE;
              if (full) begin
                push_o.status = ple_pkg::ST_FULL;
              end else begin
                mem_o.we              = 1'b1;
                count_d               = ple_pkg::CNT_W'(count_q + 1'b1);
                push_o.found_position = ple_pkg::POS_W'(count_q + 1'b1);
              end
            end
          end
          default: begin
            if (empty) begin
              if (push_ok_i) begin
                push_o.valid  = 1'b1;
                push_o.status = ple_pkg::ST_EMPTY;
                state_d       = S_IDLE;
              end
            end else if (req_q == ple_pkg::REQ_SEARCH) begin
              rd_idx_d    = '0;
              cmp_valid_d = 1'b0;
              pend_d      = 1'b0;
              state_d     = S_SCAN;
            end else if (bad_pos) begin
              if (push_ok_i) begin
                push_o.valid  = 1'b1;
                push_o.status = ple_pkg::ST_BAD_POS;
                state_d       = S_IDLE;
              end
            end else if (req_q == ple_pkg::REQ_UPDATE) begin
              if (push_ok_i) begin
                mem_o.we     = 1'b1;
                mem_o.waddr  = ple_pkg::IDX_W'(pos_m1);
                push_o.valid = 1'b1;
                state_d      = S_IDLE;
              end
            end else begin
              // delete: pull entries after the hole down by one
              rd_idx_d    = ple_pkg::CNT_W'(pos_q);
              cmp_valid_d = 1'b0;
              state_d     = S_SHIFT;
            end
          end
        endcase
      end

      S_SCAN: begin
        if (!stall) begin
          if (cmp_valid_q && match) begin
            if (pend_q) begin
              push_o.valid          = 1'b1;
              push_o.found_position = pend_pos_q;
              push_o.last           = 1'b0;
            end
            pend_d     = 1'b1;
            pend_pos_d = ple_pkg::POS_W'(cmp_idx_q + 1'b1);
          end
          if (more) begin
            mem_o.re    = 1'b1;
            cmp_idx_d   = rd_idx_q;
            rd_idx_d    = ple_pkg::CNT_W'(rd_idx_q + 1'b1);
            cmp_valid_d = 1'b1;
          end else begin
            cmp_valid_d = 1'b0;
            state_d     = S_FIN;
          end
        end
      end

      S_SHIFT: begin
        if (cmp_valid_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = ple_pkg::IDX_W'(cmp_idx_q - 1'b1);
          mem_o.wdata = rdata_i;
        end
        if (more) begin
          mem_o.re    = 1'b1;
          cmp_idx_d   = rd_idx_q;
          rd_idx_d    = ple_pkg::CNT_W'(rd_idx_q + 1'b1);
          cmp_valid_d = 1'b1;
        end else begin
          cmp_valid_d = 1'b0;
          state_d     = S_FIN;
        end
      end

      S_FIN: begin
        if (push_ok_i) begin
          push_o.valid = 1'b1;
          state_d      = S_IDLE;
          if (req_q == ple_pkg::REQ_SEARCH) begin
            if (pend_q) begin
              push_o.found_position = pend_pos_q;
            end else begin
              push_o.status = ple_pkg::ST_NOT_FOUND;
            end
          end else begin
            count_d = ple_pkg::CNT_W'(count_q - 1'b1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      pend_pos_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_valid_q <= cmp_valid_d;
      pend_q      <= pend_d;
      pend_pos_q  <= pend_pos_d;
    end
  end

  // request payload, captured on the accepted beat
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q   <= ple_pkg::req_e'(req_i.req_type);
      value_q <= req_i.value;
      pos_q   <= req_i.position;
    end
  end

  `PLE_ASSERT(a_count_bound, count_q <= ple_pkg::CNT_W'(ple_pkg::CAPACITY), "count beyond capacity")
  `PLE_ASSERT_IMP(a_push_room, push_o.valid, push_ok_i, "result pushed into a full output stage")
  `PLE_ASSERT_IMP(a_no_idle_write, state_q == S_IDLE, !mem_o.we, "ram written while idle")
  `PLE_ASSERT_IMP(a_read_in_range, mem_o.re, rd_idx_q < count_q, "ram read beyond list")
  `PLE_ASSERT_NXT(a_count_hold, state_q == S_SCAN || state_q == S_SHIFT, $stable(count_q),
    "count changed during a scan or shift")

endmodule

// File: rtl/positional_list_engine.sv
// top level of the positional list engine: entry ram, sequencer, result register
// depends on ple_pkg, ple_req_if, ple_rsp_if, ple_ram and ple_ctrl
//
// Ordered list of up to ple_pkg::CAPACITY signed 32-bit values, numbered from
// position 1, served one request at a time. The values sit in a single
// synchronous ram with one read and one write port; the length lives in a
// register and is cleared by reset, so no clearing pass runs and entries past
// the length are never read. Append, update and any error pass through
// accept, dispatch and the result register. A search walks the list one
// entry per cycle through the ram read port, holding while a match waits on a
// stalled result channel (accept, dispatch, count reads and compares, final
// beat, result register); it returns one beat per matching position,
// ascending, with last on the final beat, or a single not-found beat. A delete
// shifts every entry behind the removed one down by one, read and write
// overlapped. A new request is accepted as soon as the sequencer is idle,
// even while the last result beat still waits in the output register.
module positional_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);

  ple_pkg::push_t              push;
  ple_pkg::mem_cmd_t           mem_cmd;
  logic [ple_pkg::DATA_W-1:0]  rdata;
  logic                        push_ok;

  // result register state
  logic                        out_valid_q;
  logic [ple_pkg::ST_W-1:0]    out_status_q;
  logic [ple_pkg::POS_W-1:0]   out_pos_q;
  logic                        out_last_q;

  // the output stage takes a beat when empty or drained this cycle
  assign push_ok = !out_valid_q || rsp_o.ready;

  ple_ram #(
    .DEPTH  (ple_pkg::CAPACITY),
    .DATA_W (ple_pkg::DATA_W),
    .ADDR_W (ple_pkg::IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.we),
    .waddr_i (mem_cmd.waddr),
    .wdata_i (mem_cmd.wdata),
    .re_i    (mem_cmd.re),
    .raddr_i (mem_cmd.raddr),
    .rdata_o (rdata)
  );

  ple_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .push_ok_i (push_ok),
    .push_o    (push),
    .mem_o     (mem_cmd),
    .rdata_i   (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded only when the sequencer hands over a beat
  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_status_q <= push.status;
      out_pos_q    <= push.found_position;
      out_last_q   <= push.last;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.found_position = out_pos_q;
  assign rsp_o.last           = out_last_q;

endmodule

// File: verif/tb.sv
// self-checking testbench of the positional list engine
// depends on ple_pkg, ple_req_if, ple_rsp_if and the positional_list_engine top level
module tb;
  import ple_pkg::*;

  // generous bound: every request a full 32-beat search meeting the longest
  // stalls and gaps stays well below this
  localparam int RUN_LIMIT     = 2000000;
  // longest request is a search over a full list
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int RANDOM_ITEMS  = 350;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] fpos;
    logic             last;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  positional_list_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // period of 2 time units
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: list contents from the head and the current length
  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int unsigned              list_len;
  list_result_t             expected_results [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          gaps_on;
  bit          stalls_on;

  // idle length: mostly none or short, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic list_result_t result_beat(status_e st, int unsigned p, logic l);
    list_result_t r;
    r.status = st;
    r.fpos   = POS_W'(p);
    r.last   = l;
    return r;
  endfunction

  // update the list copy for one accepted request and queue the beats it causes
  task automatic apply_list_op(input req_e op, input logic signed [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    int unsigned hits;
    int unsigned seen;
    hits = 0;
    seen = 0;
    if (op == REQ_APPEND) begin
      if (list_len >= CAPACITY) begin
        expected_results.push_back(result_beat(ST_FULL, 0, 1'b1));
      end else begin
        list_vals[list_len] = val;
        list_len++;
        // new length, masked to the port width
        expected_results.push_back(result_beat(ST_OK, list_len, 1'b1));
      end
    end else if (list_len == 0) begin
      // empty check wins over the position check
      expected_results.push_back(result_beat(ST_EMPTY, 0, 1'b1));
    end else if (op == REQ_SEARCH) begin
      for (int unsigned i = 0; i < list_len; i++)
        if (list_vals[i] == val) hits++;
      if (hits == 0) begin
        expected_results.push_back(result_beat(ST_NOT_FOUND, 0, 1'b1));
      end else begin
        // one beat per match, ascending, last only on the final one
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) begin
            seen++;
            expected_results.push_back(result_beat(ST_OK, i + 1, seen == hits));
          end
        end
      end
    end else if (pos == 0 || pos > list_len) begin
      expected_results.push_back(result_beat(ST_BAD_POS, 0, 1'b1));
    end else begin
      if (op == REQ_UPDATE) begin
        list_vals[pos - 1] = val;
      end else begin
        // close the gap so the order of the rest is kept
        for (int unsigned i = pos - 1; i + 1 < list_len; i++)
          list_vals[i] = list_vals[i + 1];
        list_len--;
      end
      expected_results.push_back(result_beat(ST_OK, 0, 1'b1));
    end
  endtask

  // drive one request beat at the falling edge and hold it until accepted
  task automatic send_req(input req_e op, input logic signed [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.value    <= val;
    req_if.position <= pos;
    do @(posedge clk_i); while (!req_if.ready);
    apply_list_op(op, val, pos);
    items_sent++;
  endtask

  // drop valid once the stimulus of a phase is through
  task automatic idle_req();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  // small pool so that searches hit, list contents, or anything at all
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    if (roll < 65 && list_len > 0) return list_vals[$urandom_range(0, list_len - 1)];
    return $urandom();
  endfunction

  function automatic req_e pick_op();
    int unsigned roll;
    int unsigned append_wt;
    roll = $urandom_range(0, 99);
    // back off appends on a long list so deletes and searches get their turn
    append_wt = (list_len > (CAPACITY * 3) / 4) ? 15 : 35;
    if (list_len == 0 && roll < 60) return REQ_APPEND;
    if (list_len == 0) return req_e'(roll % 4);
    if (roll < append_wt) return REQ_APPEND;
    if (roll < append_wt + 30) return REQ_SEARCH;
    if (roll < append_wt + 45) return REQ_UPDATE;
    return REQ_DELETE;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input req_e op);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (list_len == 0 || op == REQ_APPEND || op == REQ_SEARCH)
      return POS_W'($urandom_range(0, 63));
    if (roll < 80) return POS_W'($urandom_range(1, list_len));
    if (roll < 90) return '0;
    return POS_W'($urandom_range(list_len + 1, 63));
  endfunction

  // append until the list is full, mostly with one value so a search hits everywhere
  task automatic fill_list(input logic signed [DATA_W-1:0] fill_val);
    while (list_len < CAPACITY)
      send_req(REQ_APPEND, ($urandom_range(0, 9) < 8) ? fill_val : pick_value(),
               POS_W'($urandom()));
  endtask

  // requests that must all report an empty list
  task automatic test_empty_list();
    send_req(REQ_SEARCH, 32'sd0, 6'd0);
    send_req(REQ_UPDATE, 32'sd7, 6'd1);
    send_req(REQ_DELETE, 32'sd0, 6'd0);
    send_req(REQ_UPDATE, -32'sd1, 6'd63);
  endtask

  // short list with the value extremes: hits, misses, bad positions, head and tail
  task automatic test_basic_ops();
    send_req(REQ_APPEND, 32'sh8000_0000, 6'd63);
    send_req(REQ_APPEND, 32'sh7fff_ffff, 6'd0);
    send_req(REQ_APPEND, -32'sd1, 6'd21);
    send_req(REQ_APPEND, 32'sh7fff_ffff, 6'd42);
    send_req(REQ_APPEND, 32'sd0, 6'd0);
    send_req(REQ_SEARCH, 32'sh7fff_ffff, 6'd63);
    send_req(REQ_SEARCH, 32'sd12345, 6'd0);
    send_req(REQ_UPDATE, 32'sd9, 6'd0);
    send_req(REQ_UPDATE, 32'sd9, 6'd6);
    send_req(REQ_DELETE, 32'sd0, 6'd63);
    send_req(REQ_UPDATE, -32'sd1, 6'd5);
    send_req(REQ_SEARCH, -32'sd1, 6'd0);
    send_req(REQ_DELETE, 32'sd0, 6'd1);
    send_req(REQ_DELETE, 32'sd0, 6'd4);
    send_req(REQ_SEARCH, 32'sh7fff_ffff, 6'd0);
    send_req(REQ_DELETE, 32'sd0, 6'd2);
    send_req(REQ_DELETE, 32'sd0, 6'd1);
    send_req(REQ_DELETE, -32'sd1, 6'd1);
    send_req(REQ_SEARCH, 32'sh8000_0000, 6'd0);
  endtask

  // full list: rejected append, a search for the value that fills most positions, trimming
  task automatic test_full_list();
    fill_list(32'sh5a5a_a5a5);
    send_req(REQ_APPEND, 32'sd1, 6'd0);
    send_req(REQ_SEARCH, 32'sh5a5a_a5a5, 6'd0);
    send_req(REQ_UPDATE, 32'sd3, 6'(CAPACITY));
    send_req(REQ_DELETE, 32'sd0, 6'(CAPACITY + 1));
    send_req(REQ_DELETE, 32'sd0, 6'(CAPACITY));
    send_req(REQ_DELETE, 32'sd0, 6'd1);
    send_req(REQ_SEARCH, 32'sd3, 6'd0);
  endtask

  // mixed traffic with idle and stall settings changing every few dozen beats
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned target;
    req_e        op;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if (items_sent % 40 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 2) begin
        fill_list(pick_value());
        send_req(REQ_SEARCH, list_vals[$urandom_range(0, CAPACITY - 1)], POS_W'($urandom()));
      end else begin
        op = pick_op();
        send_req(op, pick_value(), pick_position(op));
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input logic [POS_W-1:0] got);
    if (got !== POS_W'(want)) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side stalls at random, changes only at the falling edge
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d pos %0d last %0b",
                 $time, rsp_if.status, rsp_if.found_position, rsp_if.last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, POS_W'(rsp_if.status));
        check_field("found_position", want.fpos, rsp_if.found_position);
        check_field("last", want.last, POS_W'(rsp_if.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    list_len        = 0;
    error_count     = 0;
    items_sent      = 0;
    cycle_count     = 0;
    stall_left      = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);
    idle_req();

    // wait out every predicted beat, then give stray beats time to show up
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_req_if.sv
rtl/ple_rsp_if.sv
rtl/ple_ram.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
verif/tb.sv
